// ===== hw/rtl/mtsf_pkg.sv =====
// mtsf_pkg: shared constants, codes and types of the single-finger touch tracker
// no dependencies; every other file of the block imports it

package mtsf_pkg;

  // finger table size
  localparam int unsigned MAX_FINGERS = 10;
  localparam int unsigned IDX_W = (MAX_FINGERS > 1) ? $clog2(MAX_FINGERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_FINGERS + 1);

  // command queue between front and back, depth a power of two
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // field widths
  localparam int unsigned TYPE_W     = 5;
  localparam int unsigned CODE_W     = 10;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned EVENT_W    = 2;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned ID_W       = 17;
  localparam int unsigned THR_W      = 12;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIFF_W     = POS_W + 1;
  localparam int unsigned SQ_W       = 2 * DIFF_W;

  // evdev types and codes
  localparam logic [TYPE_W-1:0] EVT_SYN = 5'd0;
  localparam logic [TYPE_W-1:0] EVT_ABS = 5'd3;
  localparam logic [CODE_W-1:0] CODE_FRAME_END   = 10'h000;
  localparam logic [CODE_W-1:0] CODE_CONTACT_END = 10'h002;
  localparam logic [CODE_W-1:0] CODE_SLOT        = 10'h02f;
  localparam logic [CODE_W-1:0] ABS_MT_X         = 10'h035;
  localparam logic [CODE_W-1:0] ABS_MT_Y         = 10'h036;
  localparam logic [CODE_W-1:0] ABS_MT_ID        = 10'h039;

  // saturation limits
  localparam logic signed [VALUE_W-1:0] POS_MAX = 32'sd32767;
  localparam logic signed [VALUE_W-1:0] POS_MIN = -32'sd32768;
  localparam logic signed [VALUE_W-1:0] ID_MAX  = 32'sd65535;
  localparam logic signed [VALUE_W-1:0] ID_MIN  = -32'sd65536;
  localparam logic [POS_W-1:0] POS_SAT_HI = 16'h7fff;
  localparam logic [POS_W-1:0] POS_SAT_LO = 16'h8000;
  localparam logic [ID_W-1:0]  ID_SAT_HI  = 17'h0ffff;
  localparam logic [ID_W-1:0]  ID_SAT_LO  = 17'h10000;

  // "no finger" / cleared markers
  localparam logic [ID_W-1:0]  ID_NONE  = '1;
  localparam logic [POS_W-1:0] POS_NONE = '1;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 4'd1;
  localparam logic [THR_W-1:0]     THR_RESET  = 12'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE   = 2'd0,
    MODE_A      = 2'd1,
    MODE_B      = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [EVENT_W-1:0] {
    TE_PRESSED = 2'd0,
    TE_MOVED   = 2'd1,
    TE_LIFTED  = 2'd2
  } touch_event_e;

  typedef enum logic [2:0] {
    OP_WR_ID,
    OP_WR_X,
    OP_WR_Y,
    OP_WR_ALL,
    OP_SYNC
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e          op;
    logic [IDX_W-1:0] idx;
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [CNT_W-1:0] cnt;
    logic             proto_b;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DECIDE,
    BK_MUL_U,
    BK_MUL_V,
    BK_MUL_T,
    BK_CMP,
    BK_EMIT
  } back_state_e;

endpackage

// ===== hw/rtl/mtsf_if.sv =====
// mtsf channel interfaces: event input, touch result output, configuration write
// depends on mtsf_pkg for field widths

interface mtsf_ev_if;
  import mtsf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [TYPE_W-1:0]         ev_type;
  logic [CODE_W-1:0]         ev_code;
  logic signed [VALUE_W-1:0] ev_value;

  modport source (output valid, output ev_type, output ev_code, output ev_value,
                  input ready);
  modport sink   (input valid, input ev_type, input ev_code, input ev_value,
                  output ready);
endinterface

interface mtsf_touch_if;
  import mtsf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [EVENT_W-1:0]      touch_event;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;

  modport source (output valid, output touch_event, output pos_x, output pos_y,
                  input ready);
  modport sink   (input valid, input touch_event, input pos_x, input pos_y,
                  output ready);
endinterface

interface mtsf_cfg_if;
  import mtsf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/multitouch_single_finger_tracker.sv =====
// multitouch_single_finger_tracker: top level, configuration registers and the
// front end / command queue / back end chain; depends on mtsf_pkg, mtsf_if,
// mtsf_front, mtsf_fifo and mtsf_back
//
//   channel   dir  handshake     payload
//   ev_i      in   valid/ready   ev_type[4:0], ev_code[9:0], ev_value[31:0] signed
//   touch_o   out  valid/ready   touch_event[1:0], pos_x[15:0], pos_y[15:0] signed
//   cfg_i     in   valid/ready   index[3:0] (0 protocol mode, 1 drag threshold), data[31:0]
//
// an event beat is taken whenever the command queue has room; slot, pending
// contact and contact count live in the front end, so every beat is classified
// in the cycle it arrives. the back end takes table writes one command at a
// time in its idle state; a sync report leaves the queue, then the scan visits
// the table entries in turn (contact count in protocol A, MAX_FINGERS in protocol
// B), then come a decide state, the multiply states for u, v and the threshold
// and a compare when the finger stays down, and last the result register load.
// reset clears the finger table, tracking state and the queue at once, no
// clearing pass. a result waiting on touch_o stalls only the back end once it
// has the next result ready; the front keeps taking beats until the queue fills

module multitouch_single_finger_tracker (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtsf_ev_if.sink    ev_i,
  mtsf_touch_if.source touch_o,
  mtsf_cfg_if.sink   cfg_i
);
  import mtsf_pkg::*;

  // configuration registers; the user writes them only while the block is quiet, the block does not enforce it
  mode_e            mode_q, mode_d;
  logic [THR_W-1:0] thr_q, thr_d;

  // front to queue
  logic  push;
  cmd_t  push_cmd;
  logic  fifo_full;

  // queue to back
  logic  cmd_valid;
  cmd_t  cmd_head;
  logic  pop;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    mode_d = mode_q;
    thr_d  = thr_q;
    if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == CFG_MODE) begin
        mode_d = mode_e'(cfg_i.data[MODE_W-1:0]);
      end else if (cfg_i.index == CFG_THRESH) begin
        thr_d = cfg_i.data[THR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE;
      thr_q  <= THR_RESET;
    end else begin
      mode_q <= mode_d;
      thr_q  <= thr_d;
    end
  end

  // event classification; mode 3 falls through as ignored
  mtsf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_i        (ev_i),
    .mode_i      (mode_q),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // decouples event intake from the table scan
  mtsf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (fifo_full),
    .valid_o (cmd_valid),
    .data_o  (cmd_head),
    .pop_i   (pop)
  );

  // finger table, tracking and result generation
  mtsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .pop_o       (pop),
    .thr_i       (thr_q),
    .touch_o     (touch_o)
  );

endmodule

// ===== hw/rtl/mtsf_fifo.sv =====
// mtsf_fifo: short command queue between the event front end and the table back end
// depends on mtsf_pkg (cmd_t, queue depth)

module mtsf_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mtsf_pkg::cmd_t data_i,
  output logic          full_o,
  output logic          valid_o,
  output mtsf_pkg::cmd_t data_o,
  input  logic          pop_i
);
  import mtsf_pkg::*;

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + FIFO_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + FIFO_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/mtsf_front.sv =====
// mtsf_front: takes evdev beats, saturates values, keeps slot and pending contact,
// and turns each meaningful beat into a table command; depends on mtsf_pkg, mtsf_if

module mtsf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  mtsf_ev_if.sink         ev_i,
  input  mtsf_pkg::mode_e mode_i,
  input  logic            fifo_full_i,
  output logic            push_o,
  output mtsf_pkg::cmd_t  cmd_o
);
  import mtsf_pkg::*;

  logic             accept;
  logic [POS_W-1:0] coord;
  logic [ID_W-1:0]  id_sat;

  logic [ID_W-1:0]  pend_id_q, pend_id_d;
  logic [POS_W-1:0] pend_x_q, pend_x_d;
  logic [POS_W-1:0] pend_y_q, pend_y_d;
  logic [CNT_W-1:0] rep_cnt_q, rep_cnt_d;
  logic             slot_ok_q, slot_ok_d;
  logic [IDX_W-1:0] slot_idx_q, slot_idx_d;

  assign ev_i.ready = !fifo_full_i;
  assign accept     = ev_i.valid && ev_i.ready;

  // saturation of coordinates and tracking ids
  always_comb begin
    if (ev_i.ev_value > POS_MAX) begin
      coord = POS_SAT_HI;
    end else if (ev_i.ev_value < POS_MIN) begin
      coord = POS_SAT_LO;
    end else begin
      coord = ev_i.ev_value[POS_W-1:0];
    end
    if (ev_i.ev_value > ID_MAX) begin
      id_sat = ID_SAT_HI;
    end else if (ev_i.ev_value < ID_MIN) begin
      id_sat = ID_SAT_LO;
    end else begin
      id_sat = ev_i.ev_value[ID_W-1:0];
    end
  end

  always_comb begin
    pend_id_d     = pend_id_q;
    pend_x_d      = pend_x_q;
    pend_y_d      = pend_y_q;
    rep_cnt_d     = rep_cnt_q;
    slot_ok_d     = slot_ok_q;
    slot_idx_d    = slot_idx_q;
    push_o        = 1'b0;
    cmd_o.op      = OP_WR_ID;
    cmd_o.idx     = slot_idx_q;
    cmd_o.id      = id_sat;
    cmd_o.x       = coord;
    cmd_o.y       = coord;
    cmd_o.cnt     = rep_cnt_q;
    cmd_o.proto_b = 1'b0;

    if (accept) begin
      case (mode_i)
        MODE_A: begin
          if (ev_i.ev_type == EVT_ABS) begin
            case (ev_i.ev_code)
              ABS_MT_ID: pend_id_d = id_sat;
              ABS_MT_X:  pend_x_d  = coord;
              ABS_MT_Y:  pend_y_d  = coord;
              default: ;
            endcase
          end else if (ev_i.ev_type == EVT_SYN) begin
            if (ev_i.ev_code == CODE_CONTACT_END) begin
              // commit a complete contact while the table has room
              if (pend_x_q != POS_NONE && pend_y_q != POS_NONE &&
                  rep_cnt_q < CNT_W'(MAX_FINGERS)) begin
                push_o    = 1'b1;
                cmd_o.op  = OP_WR_ALL;
                cmd_o.idx = rep_cnt_q[IDX_W-1:0];
                cmd_o.id  = (pend_id_q == ID_NONE) ? '0 : pend_id_q;
                cmd_o.x   = pend_x_q;
                cmd_o.y   = pend_y_q;
                rep_cnt_d = rep_cnt_q + CNT_W'(1);
              end
              pend_id_d = ID_NONE;
              pend_x_d  = POS_NONE;
              pend_y_d  = POS_NONE;
            end else if (ev_i.ev_code == CODE_FRAME_END) begin
              push_o    = 1'b1;
              cmd_o.op  = OP_SYNC;
              cmd_o.cnt = rep_cnt_q;
              rep_cnt_d = '0;
            end
          end
        end
        MODE_B: begin
          if (ev_i.ev_type == EVT_ABS) begin
            if (ev_i.ev_code == CODE_SLOT) begin
              slot_ok_d  = ($unsigned(ev_i.ev_value) < VALUE_W'(MAX_FINGERS));
              slot_idx_d = ev_i.ev_value[IDX_W-1:0];
            end else if (slot_ok_q) begin
              case (ev_i.ev_code)
                ABS_MT_ID: begin
                  push_o   = 1'b1;
                  cmd_o.op = OP_WR_ID;
                end
                ABS_MT_X: begin
                  push_o   = 1'b1;
                  cmd_o.op = OP_WR_X;
                end
                ABS_MT_Y: begin
                  push_o   = 1'b1;
                  cmd_o.op = OP_WR_Y;
                end
                default: ;
              endcase
            end
          end else if (ev_i.ev_type == EVT_SYN && ev_i.ev_code == CODE_FRAME_END) begin
            push_o        = 1'b1;
            cmd_o.op      = OP_SYNC;
            cmd_o.cnt     = CNT_W'(MAX_FINGERS);
            cmd_o.proto_b = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_id_q  <= ID_NONE;
      pend_x_q   <= POS_NONE;
      pend_y_q   <= POS_NONE;
      rep_cnt_q  <= '0;
      slot_ok_q  <= 1'b1;
      slot_idx_q <= '0;
    end else begin
      pend_id_q  <= pend_id_d;
      pend_x_q   <= pend_x_d;
      pend_y_q   <= pend_y_d;
      rep_cnt_q  <= rep_cnt_d;
      slot_ok_q  <= slot_ok_d;
      slot_idx_q <= slot_idx_d;
    end
  end

endmodule

// ===== hw/rtl/mtsf_back.sv =====
// mtsf_back: finger table, tracking scan, displacement check and result register
// depends on mtsf_pkg (cmd_t, back_state_e) and mtsf_if (touch channel)

module mtsf_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  mtsf_pkg::cmd_t               cmd_i,
  output logic                         pop_o,
  input  logic [mtsf_pkg::THR_W-1:0]   thr_i,
  mtsf_touch_if.source                 touch_o
);
  import mtsf_pkg::*;

  back_state_e        state_q, state_d;
  logic [ID_W-1:0]    fid_q [MAX_FINGERS];
  logic [ID_W-1:0]    fid_d [MAX_FINGERS];
  logic [POS_W-1:0]   fx_q [MAX_FINGERS];
  logic [POS_W-1:0]   fx_d [MAX_FINGERS];
  logic [POS_W-1:0]   fy_q [MAX_FINGERS];
  logic [POS_W-1:0]   fy_d [MAX_FINGERS];

  logic               tracking_q, tracking_d;
  logic               touching_q, touching_d;
  logic [ID_W-1:0]    tracked_id_q, tracked_id_d;
  logic [2*POS_W-1:0] active_q, active_d;
  logic [2*POS_W-1:0] last_q, last_d;

  logic [CNT_W-1:0]   scan_cnt_q, scan_cnt_d;
  logic [CNT_W-1:0]   scan_n_q, scan_n_d;
  logic               proto_b_q, proto_b_d;
  logic               found_q, found_d;
  logic               any_q, any_d;

  logic [SQ_W-1:0]    sq_u_q, sq_u_d;
  logic [SQ_W-1:0]    sq_v_q, sq_v_d;
  logic [SQ_W-1:0]    thr_sq_q, thr_sq_d;
  touch_event_e       kind_q, kind_d;

  logic               out_valid_q, out_valid_d;
  touch_event_e       out_event_q, out_event_d;
  logic [2*POS_W-1:0] out_xy_q, out_xy_d;

  logic [IDX_W-1:0]         ent_idx;
  logic [ID_W-1:0]          e_id;
  logic                     e_valid;
  logic                     match;
  logic signed [DIFF_W-1:0] du, dv, mul_a;
  logic signed [SQ_W-1:0]   prod;
  logic [SQ_W:0]            dist_sum;

  assign ent_idx = scan_cnt_q[IDX_W-1:0];
  assign e_id    = fid_q[ent_idx];
  assign e_valid = (e_id != ID_NONE);
  assign match   = tracking_q ? (e_valid && e_id == tracked_id_q) : e_valid;

  // displacement since the last report, one shared multiplier
  assign du = $signed({last_q[POS_W-1], last_q[POS_W-1:0]}) -
              $signed({active_q[POS_W-1], active_q[POS_W-1:0]});
  assign dv = $signed({last_q[2*POS_W-1], last_q[2*POS_W-1:POS_W]}) -
              $signed({active_q[2*POS_W-1], active_q[2*POS_W-1:POS_W]});

  always_comb begin
    case (state_q)
      BK_MUL_U: mul_a = du;
      BK_MUL_V: mul_a = dv;
      default:  mul_a = $signed({{(DIFF_W-THR_W){1'b0}}, thr_i});
    endcase
  end

  assign prod     = mul_a * mul_a;
  assign dist_sum = {1'b0, sq_u_q} + {1'b0, sq_v_q};

  assign touch_o.valid       = out_valid_q;
  assign touch_o.touch_event = out_event_q;
  assign touch_o.pos_x       = $signed(out_xy_q[POS_W-1:0]);
  assign touch_o.pos_y       = $signed(out_xy_q[2*POS_W-1:POS_W]);

  always_comb begin
    state_d      = state_q;
    fid_d        = fid_q;
    fx_d         = fx_q;
    fy_d         = fy_q;
    tracking_d   = tracking_q;
    touching_d   = touching_q;
    tracked_id_d = tracked_id_q;
    active_d     = active_q;
    last_d       = last_q;
    scan_cnt_d   = scan_cnt_q;
    scan_n_d     = scan_n_q;
    proto_b_d    = proto_b_q;
    found_d      = found_q;
    any_d        = any_q;
    sq_u_d       = sq_u_q;
    sq_v_d       = sq_v_q;
    thr_sq_d     = thr_sq_q;
    kind_d       = kind_q;
    out_valid_d  = out_valid_q;
    out_event_d  = out_event_q;
    out_xy_d     = out_xy_q;
    pop_o        = 1'b0;

    if (out_valid_q && touch_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            OP_WR_ID: fid_d[cmd_i.idx] = cmd_i.id;
            OP_WR_X:  fx_d[cmd_i.idx]  = cmd_i.x;
            OP_WR_Y:  fy_d[cmd_i.idx]  = cmd_i.y;
            OP_WR_ALL: begin
              fid_d[cmd_i.idx] = cmd_i.id;
              fx_d[cmd_i.idx]  = cmd_i.x;
              fy_d[cmd_i.idx]  = cmd_i.y;
            end
            OP_SYNC: begin
              scan_cnt_d = '0;
              scan_n_d   = cmd_i.cnt;
              proto_b_d  = cmd_i.proto_b;
              found_d    = 1'b0;
              any_d      = 1'b0;
              state_d    = (cmd_i.cnt == '0) ? BK_DECIDE : BK_SCAN;
            end
            default: ;
          endcase
        end
      end
      BK_SCAN: begin
        any_d = any_q | e_valid;
        // first hit wins
        if (match && !found_q) begin
          found_d  = 1'b1;
          active_d = {fy_q[ent_idx], fx_q[ent_idx]};
          if (!tracking_q) begin
            tracked_id_d = e_id;
          end
        end
        scan_cnt_d = scan_cnt_q + CNT_W'(1);
        if (scan_cnt_d == scan_n_q) begin
          state_d = BK_DECIDE;
        end
      end
      BK_DECIDE: begin
        if (tracking_q) begin
          tracking_d = proto_b_q ? any_q : (scan_n_q != '0);
        end else begin
          tracking_d = found_q;
        end
        if (touching_q != found_q) begin
          touching_d = found_q;
          if (found_q) begin
            last_d = active_q;
            kind_d = TE_PRESSED;
          end else begin
            tracked_id_d = ID_NONE;
            kind_d       = TE_LIFTED;
          end
          state_d = BK_EMIT;
        end else if (touching_q) begin
          state_d = BK_MUL_U;
        end else begin
          state_d = BK_IDLE;
        end
      end
      BK_MUL_U: begin
        sq_u_d  = $unsigned(prod);
        state_d = BK_MUL_V;
      end
      BK_MUL_V: begin
        sq_v_d  = $unsigned(prod);
        state_d = BK_MUL_T;
      end
      BK_MUL_T: begin
        thr_sq_d = $unsigned(prod);
        state_d  = BK_CMP;
      end
      BK_CMP: begin
        if (dist_sum >= {1'b0, thr_sq_q}) begin
          last_d  = active_q;
          kind_d  = TE_MOVED;
          state_d = BK_EMIT;
        end else begin
          state_d = BK_IDLE;
        end
      end
      BK_EMIT: begin
        if (!out_valid_q || touch_o.ready) begin
          out_valid_d = 1'b1;
          out_event_d = kind_q;
          out_xy_d    = active_q;
          state_d     = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      for (int i = 0; i < MAX_FINGERS; i++) begin
        fid_q[i] <= ID_NONE;
        fx_q[i]  <= POS_NONE;
        fy_q[i]  <= POS_NONE;
      end
      tracking_q   <= 1'b0;
      touching_q   <= 1'b0;
      tracked_id_q <= ID_NONE;
      active_q     <= '0;
      last_q       <= '0;
      scan_cnt_q   <= '0;
      scan_n_q     <= '0;
      proto_b_q    <= 1'b0;
      found_q      <= 1'b0;
      any_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fid_q        <= fid_d;
      fx_q         <= fx_d;
      fy_q         <= fy_d;
      tracking_q   <= tracking_d;
      touching_q   <= touching_d;
      tracked_id_q <= tracked_id_d;
      active_q     <= active_d;
      last_q       <= last_d;
      scan_cnt_q   <= scan_cnt_d;
      scan_n_q     <= scan_n_d;
      proto_b_q    <= proto_b_d;
      found_q      <= found_d;
      any_q        <= any_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sq_u_q      <= sq_u_d;
    sq_v_q      <= sq_v_d;
    thr_sq_q    <= thr_sq_d;
    kind_q      <= kind_d;
    out_event_q <= out_event_d;
    out_xy_q    <= out_xy_d;
  end

endmodule
